### rtl/mpc_pkg.sv
// Package with the shared pipeline control type of the marker pose block.
`default_nettype none
package mpc_pkg;

    // Number of components in one 3D vector.
    localparam int AXES = 3;

    // Pipeline control that every stage of the datapath follows.
    typedef struct packed {
        logic advance;
    } t_pipe_ctl;

endpackage
`default_nettype wire

### rtl/mpc_corner_if.sv
// Interface that carries one item of four marker corners.
`default_nettype none
interface mpc_corner_if #(
    parameter int CW = 32
);
    logic              valid;
    logic              ready;
    logic signed [CW-1:0] corner0_x;
    logic signed [CW-1:0] corner0_y;
    logic signed [CW-1:0] corner0_z;
    logic signed [CW-1:0] corner1_x;
    logic signed [CW-1:0] corner1_y;
    logic signed [CW-1:0] corner1_z;
    logic signed [CW-1:0] corner2_x;
    logic signed [CW-1:0] corner2_y;
    logic signed [CW-1:0] corner2_z;
    logic signed [CW-1:0] corner3_x;
    logic signed [CW-1:0] corner3_y;
    logic signed [CW-1:0] corner3_z;

    modport source (
        output valid, corner0_x, corner0_y, corner0_z, corner1_x, corner1_y, corner1_z,
               corner2_x, corner2_y, corner2_z, corner3_x, corner3_y, corner3_z,
        input  ready
    );
    modport sink (
        input  valid, corner0_x, corner0_y, corner0_z, corner1_x, corner1_y, corner1_z,
               corner2_x, corner2_y, corner2_z, corner3_x, corner3_y, corner3_z,
        output ready
    );
endinterface
`default_nettype wire

### rtl/mpc_pose_if.sv
// Interface that carries one item of marker pose results.
`default_nettype none
interface mpc_pose_if #(
    parameter int CW = 32,
    parameter int FB = 16
);
    logic                 valid;
    logic                 ready;
    logic signed [FB+1:0] axis_x_dir_x;
    logic signed [FB+1:0] axis_x_dir_y;
    logic signed [FB+1:0] axis_x_dir_z;
    logic signed [FB+1:0] axis_y_dir_x;
    logic signed [FB+1:0] axis_y_dir_y;
    logic signed [FB+1:0] axis_y_dir_z;
    logic signed [FB+1:0] axis_z_dir_x;
    logic signed [FB+1:0] axis_z_dir_y;
    logic signed [FB+1:0] axis_z_dir_z;
    logic signed [CW-1:0] center_x;
    logic signed [CW-1:0] center_y;
    logic signed [CW-1:0] center_z;

    modport source (
        output valid, axis_x_dir_x, axis_x_dir_y, axis_x_dir_z,
               axis_y_dir_x, axis_y_dir_y, axis_y_dir_z,
               axis_z_dir_x, axis_z_dir_y, axis_z_dir_z,
               center_x, center_y, center_z,
        input  ready
    );
    modport sink (
        input  valid, axis_x_dir_x, axis_x_dir_y, axis_x_dir_z,
               axis_y_dir_x, axis_y_dir_y, axis_y_dir_z,
               axis_z_dir_x, axis_z_dir_y, axis_z_dir_z,
               center_x, center_y, center_z,
        output ready
    );
endinterface
`default_nettype wire

### rtl/mpc_delay.sv
// Enabled shift register that delays a payload word by a fixed number of stages.
`default_nettype none
module mpc_delay #(
    parameter int W = 8,
    parameter int N = 1
) (
    input  wire                    i_clk,
    input  mpc_pkg::t_pipe_ctl     i_ctl,
    input  wire  [W-1:0]           i_data,
    output logic [W-1:0]           o_data
);
    import mpc_pkg::*;

    logic [W-1:0] r_tap [N];

    // Taps shift together with the rest of the pipeline.
    always_ff @(posedge i_clk) begin
        if (i_ctl.advance) begin
            r_tap[0] <= i_data;
            for (int i = 1; i < N; i++) begin
                r_tap[i] <= r_tap[i-1];
            end
        end
    end

    assign o_data = r_tap[N-1];
endmodule
`default_nettype wire

### rtl/mpc_mul.sv
// Two-stage unsigned multiplier built from four half-width partial products.
`default_nettype none
module mpc_mul #(
    parameter int W = 33
) (
    input  wire                    i_clk,
    input  mpc_pkg::t_pipe_ctl     i_ctl,
    input  wire  [W-1:0]           i_a,
    input  wire  [W-1:0]           i_b,
    output logic [2*W-1:0]         o_p
);
    import mpc_pkg::*;

    localparam int H  = (W + 1) / 2;
    localparam int PW = 4 * H;

    logic [H-1:0]   w_al, w_ah, w_bl, w_bh;
    logic [2*H-1:0] r_ll, r_lh, r_hl, r_hh;
    logic [PW-1:0]  w_sum;
    logic [2*W-1:0] r_p;

    // Split both operands into low and high halves.
    assign w_al = i_a[H-1:0];
    assign w_bl = i_b[H-1:0];
    assign w_ah = H'(i_a >> H);
    assign w_bh = H'(i_b >> H);

    // First stage: partial products.
    always_ff @(posedge i_clk) begin
        if (i_ctl.advance) begin
            r_ll <= w_al * w_bl;
            r_lh <= w_al * w_bh;
            r_hl <= w_ah * w_bl;
            r_hh <= w_ah * w_bh;
        end
    end

    // Second stage: shifted sum of the partial products.
    assign w_sum = PW'(r_ll) + (PW'(r_lh) << H) + (PW'(r_hl) << H) + (PW'(r_hh) << (2 * H));

    always_ff @(posedge i_clk) begin
        if (i_ctl.advance) begin
            r_p <= w_sum[2*W-1:0];
        end
    end

    assign o_p = r_p;
endmodule
`default_nettype wire

### rtl/mpc_norm.sv
// Pipelined exact normalizer: floor(v * 2^FB / sqrt(S)), one root bit per stage.
`default_nettype none
module mpc_norm #(
    parameter int VW = 66,
    parameter int FB = 16
) (
    input  wire                    i_clk,
    input  mpc_pkg::t_pipe_ctl     i_ctl,
    input  wire  [VW+1:0]          i_sum,
    input  wire  [VW-1:0]          i_sq,
    input  wire                    i_neg,
    output logic signed [FB+1:0]   o_dir
);
    import mpc_pkg::*;

    localparam int SW = VW + 2;
    localparam int RW = VW + 2 * FB;
    localparam int PW = SW + FB + 1;
    localparam int XW = SW + 2 * FB + 3;
    localparam int NS = FB + 1;
    localparam int MW = FB + 1;

    logic [RW-1:0] r_rem  [NS];
    logic [PW-1:0] r_prod [NS];
    logic [SW-1:0] r_sum  [NS];
    logic [MW-1:0] r_root [NS];
    logic          r_neg  [NS];
    logic          r_zero [NS];
    logic signed [FB+1:0] r_dir;

    // One stage per root bit, most significant bit first. The remainder holds
    // T - m*m*S and the running product m*S, so each trial is shifts and one add.
    for (genvar j = 0; j < NS; j++) begin : g_stage
        localparam int B = FB - j;
        logic [RW-1:0] w_rem;
        logic [PW-1:0] w_prod;
        logic [SW-1:0] w_sum;
        logic [MW-1:0] w_root;
        logic          w_neg;
        logic          w_zero;
        logic [XW-1:0] w_trial;
        logic          w_fit;

        if (j == 0) begin : g_first
            assign w_rem  = {i_sq, {(2*FB){1'b0}}};
            assign w_prod = '0;
            assign w_sum  = i_sum;
            assign w_root = '0;
            assign w_neg  = i_neg;
            assign w_zero = (i_sum == '0);
        end else begin : g_next
            assign w_rem  = r_rem[j-1];
            assign w_prod = r_prod[j-1];
            assign w_sum  = r_sum[j-1];
            assign w_root = r_root[j-1];
            assign w_neg  = r_neg[j-1];
            assign w_zero = r_zero[j-1];
        end

        assign w_trial = (XW'(w_prod) << (B + 1)) + (XW'(w_sum) << (2 * B));
        assign w_fit   = (w_trial <= XW'(w_rem));

        always_ff @(posedge i_clk) begin
            if (i_ctl.advance) begin
                r_rem[j]  <= w_fit ? (w_rem - w_trial[RW-1:0]) : w_rem;
                r_prod[j] <= w_fit ? (w_prod + (PW'(w_sum) << B)) : w_prod;
                r_root[j] <= w_fit ? (w_root | (MW'(1) << B)) : w_root;
                r_sum[j]  <= w_sum;
                r_neg[j]  <= w_neg;
                r_zero[j] <= w_zero;
            end
        end
    end

    // Negative components round the magnitude up; a zero vector gives zero.
    logic [MW-1:0] w_mag;
    assign w_mag = r_root[NS-1] + MW'(r_neg[NS-1] && (r_rem[NS-1] != '0));

    always_ff @(posedge i_clk) begin
        if (i_ctl.advance) begin
            if (r_zero[NS-1]) begin
                r_dir <= '0;
            end else if (r_neg[NS-1]) begin
                r_dir <= -$signed((FB+2)'(w_mag));
            end else begin
                r_dir <= $signed((FB+2)'(w_mag));
            end
        end
    end

    assign o_dir = r_dir;
endmodule
`default_nettype wire

### rtl/marker_pose_from_corners.sv
// Top level of the marker pose block: axis differences, cross product, normalizers.
// Throughput: one item per cycle while the skid register is free; the exact normalizers
// resolve one root bit per stage. A skid register at the output takes the last stage's
// item when the sink stalls, and while it is full no input is accepted.
// Reset clears the stage valid bits and the skid valid bit; payload is not reset.
`default_nettype none
module marker_pose_from_corners #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    mpc_corner_if.sink  i_corners,
    mpc_pose_if.source  o_pose
);
    import mpc_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int FB  = FRAC_BITS;
    localparam int DW  = CW + 1;
    localparam int ZM  = 2 * DW;
    localparam int LAT = FB + 9;
    localparam int OW  = FB + 2;

    t_pipe_ctl w_ctl;
    logic [LAT-1:0] r_vld;
    logic           r_skid_vld;

    // The pipeline moves whenever the skid register is free.
    assign w_ctl.advance   = !r_skid_vld;
    assign i_corners.ready = !r_skid_vld;

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_ctl.advance) begin
            r_vld <= {r_vld[LAT-2:0], i_corners.valid};
        end
    end

    // Corner coordinates as arrays.
    logic signed [CW-1:0] w_c0 [AXES];
    logic signed [CW-1:0] w_c1 [AXES];
    logic signed [CW-1:0] w_c2z, w_c3z, w_c3y;
    assign w_c0[0] = i_corners.corner0_x;
    assign w_c0[1] = i_corners.corner0_y;
    assign w_c0[2] = i_corners.corner0_z;
    assign w_c1[0] = i_corners.corner1_x;
    assign w_c1[1] = i_corners.corner1_y;
    assign w_c1[2] = i_corners.corner1_z;
    assign w_c2z   = i_corners.corner2_z;
    assign w_c3y   = i_corners.corner3_y;
    assign w_c3z   = i_corners.corner3_z;

    logic signed [CW-1:0] w_c3 [AXES];
    assign w_c3[0] = i_corners.corner3_x;
    assign w_c3[1] = w_c3y;
    assign w_c3[2] = w_c3z;

    // First stage: axis differences as magnitude and sign, and the center.
    logic [DW-1:0] r_a_xm [AXES];
    logic [DW-1:0] r_a_ym [AXES];
    logic          r_a_xn [AXES];
    logic          r_a_yn [AXES];
    logic [CW-1:0] r_a_ctr [AXES];

    for (genvar k = 0; k < AXES; k++) begin : g_diff
        logic signed [DW-1:0] w_dx, w_dy;
        assign w_dx = $signed({w_c1[k][CW-1], w_c1[k]}) - $signed({w_c0[k][CW-1], w_c0[k]});
        assign w_dy = $signed({w_c0[k][CW-1], w_c0[k]}) - $signed({w_c3[k][CW-1], w_c3[k]});
        always_ff @(posedge i_clk) begin
            if (w_ctl.advance) begin
                r_a_xm[k] <= w_dx[DW-1] ? DW'(-w_dx) : DW'(w_dx);
                r_a_ym[k] <= w_dy[DW-1] ? DW'(-w_dy) : DW'(w_dy);
                r_a_xn[k] <= w_dx[DW-1];
                r_a_yn[k] <= w_dy[DW-1];
            end
        end
    end

    // Center: half steps from corner zero, and the floored mean of the z values.
    logic signed [DW-1:0]   w_hx, w_hy;
    logic signed [DW-1:0]   w_cx, w_cy;
    logic signed [CW+1:0]   w_zsum, w_cz;
    assign w_hx   = $signed({w_c1[0][CW-1], w_c1[0]}) - $signed({w_c0[0][CW-1], w_c0[0]});
    assign w_hy   = $signed({w_c3y[CW-1], w_c3y}) - $signed({w_c0[1][CW-1], w_c0[1]});
    assign w_cx   = $signed({w_c0[0][CW-1], w_c0[0]}) + (w_hx >>> 1);
    assign w_cy   = $signed({w_c0[1][CW-1], w_c0[1]}) + (w_hy >>> 1);
    assign w_zsum = (CW+2)'(w_c0[2]) + (CW+2)'(w_c1[2]) + (CW+2)'(w_c2z) + (CW+2)'(w_c3z);
    assign w_cz   = w_zsum >>> 2;

    always_ff @(posedge i_clk) begin
        if (w_ctl.advance) begin
            r_a_ctr[0] <= w_cx[CW-1:0];
            r_a_ctr[1] <= w_cy[CW-1:0];
            r_a_ctr[2] <= w_cz[CW-1:0];
        end
    end

    // Squares of the axis components and cross product terms.
    logic [ZM-1:0] w_xsq [AXES];
    logic [ZM-1:0] w_ysq [AXES];
    logic [ZM-1:0] w_pp  [AXES];
    logic [ZM-1:0] w_qq  [AXES];
    logic          w_pn  [AXES];
    logic          w_qn  [AXES];

    for (genvar k = 0; k < AXES; k++) begin : g_mul
        localparam int A = (k + 1) % AXES;
        localparam int B = (k + 2) % AXES;
        mpc_mul #(.W(DW)) u_xsq (.i_clk(i_clk), .i_ctl(w_ctl),
            .i_a(r_a_xm[k]), .i_b(r_a_xm[k]), .o_p(w_xsq[k]));
        mpc_mul #(.W(DW)) u_ysq (.i_clk(i_clk), .i_ctl(w_ctl),
            .i_a(r_a_ym[k]), .i_b(r_a_ym[k]), .o_p(w_ysq[k]));
        mpc_mul #(.W(DW)) u_p (.i_clk(i_clk), .i_ctl(w_ctl),
            .i_a(r_a_xm[A]), .i_b(r_a_ym[B]), .o_p(w_pp[k]));
        mpc_mul #(.W(DW)) u_q (.i_clk(i_clk), .i_ctl(w_ctl),
            .i_a(r_a_xm[B]), .i_b(r_a_ym[A]), .o_p(w_qq[k]));
        mpc_delay #(.W(2), .N(2)) u_pqn (.i_clk(i_clk), .i_ctl(w_ctl),
            .i_data({r_a_xn[A] ^ r_a_yn[B], r_a_xn[B] ^ r_a_yn[A]}),
            .o_data({w_pn[k], w_qn[k]}));
    end

    // Fourth stage: cross product components and the sums of squares of X and Y.
    logic [ZM-1:0]   r_d_zm [AXES];
    logic            r_d_zn [AXES];
    logic [ZM+1:0]   r_d_sx, r_d_sy;

    for (genvar k = 0; k < AXES; k++) begin : g_cross
        logic signed [ZM:0]   w_ps, w_qs;
        logic signed [ZM+1:0] w_zs, w_zneg;
        assign w_ps   = w_pn[k] ? -$signed({1'b0, w_pp[k]}) : $signed({1'b0, w_pp[k]});
        assign w_qs   = w_qn[k] ? -$signed({1'b0, w_qq[k]}) : $signed({1'b0, w_qq[k]});
        assign w_zs   = $signed({w_ps[ZM], w_ps}) - $signed({w_qs[ZM], w_qs});
        assign w_zneg = -w_zs;
        always_ff @(posedge i_clk) begin
            if (w_ctl.advance) begin
                r_d_zm[k] <= w_zs[ZM+1] ? w_zneg[ZM-1:0] : w_zs[ZM-1:0];
                r_d_zn[k] <= w_zs[ZM+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.advance) begin
            r_d_sx <= (ZM+2)'(w_xsq[0]) + (ZM+2)'(w_xsq[1]) + (ZM+2)'(w_xsq[2]);
            r_d_sy <= (ZM+2)'(w_ysq[0]) + (ZM+2)'(w_ysq[1]) + (ZM+2)'(w_ysq[2]);
        end
    end

    // Squares of the cross product, then its sum of squares.
    logic [2*ZM-1:0] w_zsq   [AXES];
    logic [2*ZM-1:0] w_g_zsq [AXES];
    logic [2*ZM+1:0] r_g_sz;

    for (genvar k = 0; k < AXES; k++) begin : g_zsq
        mpc_mul #(.W(ZM)) u_zsq (.i_clk(i_clk), .i_ctl(w_ctl),
            .i_a(r_d_zm[k]), .i_b(r_d_zm[k]), .o_p(w_zsq[k]));
        mpc_delay #(.W(2*ZM), .N(1)) u_zsq_dly (.i_clk(i_clk), .i_ctl(w_ctl),
            .i_data(w_zsq[k]), .o_data(w_g_zsq[k]));
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.advance) begin
            r_g_sz <= (2*ZM+2)'(w_zsq[0]) + (2*ZM+2)'(w_zsq[1]) + (2*ZM+2)'(w_zsq[2]);
        end
    end

    // Align X and Y operands with the cross product sums.
    logic [ZM+1:0] w_g_sx, w_g_sy;
    mpc_delay #(.W(ZM+2), .N(3)) u_sx_dly (.i_clk(i_clk), .i_ctl(w_ctl),
        .i_data(r_d_sx), .o_data(w_g_sx));
    mpc_delay #(.W(ZM+2), .N(3)) u_sy_dly (.i_clk(i_clk), .i_ctl(w_ctl),
        .i_data(r_d_sy), .o_data(w_g_sy));

    logic signed [OW-1:0] w_dir [3*AXES];

    for (genvar k = 0; k < AXES; k++) begin : g_norm
        logic [ZM-1:0] w_gx, w_gy;
        logic          w_gxn, w_gyn, w_gzn;
        mpc_delay #(.W(ZM), .N(4)) u_xsq_dly (.i_clk(i_clk), .i_ctl(w_ctl),
            .i_data(w_xsq[k]), .o_data(w_gx));
        mpc_delay #(.W(ZM), .N(4)) u_ysq_dly (.i_clk(i_clk), .i_ctl(w_ctl),
            .i_data(w_ysq[k]), .o_data(w_gy));
        mpc_delay #(.W(2), .N(6)) u_xyn_dly (.i_clk(i_clk), .i_ctl(w_ctl),
            .i_data({r_a_xn[k], r_a_yn[k]}), .o_data({w_gxn, w_gyn}));
        mpc_delay #(.W(1), .N(3)) u_zn_dly (.i_clk(i_clk), .i_ctl(w_ctl),
            .i_data(r_d_zn[k]), .o_data(w_gzn));

        mpc_norm #(.VW(ZM), .FB(FB)) u_nx (.i_clk(i_clk), .i_ctl(w_ctl),
            .i_sum(w_g_sx), .i_sq(w_gx), .i_neg(w_gxn), .o_dir(w_dir[k]));
        mpc_norm #(.VW(ZM), .FB(FB)) u_ny (.i_clk(i_clk), .i_ctl(w_ctl),
            .i_sum(w_g_sy), .i_sq(w_gy), .i_neg(w_gyn), .o_dir(w_dir[AXES+k]));
        mpc_norm #(.VW(2*ZM), .FB(FB)) u_nz (.i_clk(i_clk), .i_ctl(w_ctl),
            .i_sum(r_g_sz), .i_sq(w_g_zsq[k]), .i_neg(w_gzn), .o_dir(w_dir[2*AXES+k]));
    end

    // Center travels alongside the normalizers.
    logic [CW-1:0] w_ctr [AXES];
    for (genvar k = 0; k < AXES; k++) begin : g_ctr
        mpc_delay #(.W(CW), .N(LAT-1)) u_ctr_dly (.i_clk(i_clk), .i_ctl(w_ctl),
            .i_data(r_a_ctr[k]), .o_data(w_ctr[k]));
    end

    // Skid register: takes the last stage's item when the sink stalls.
    logic signed [OW-1:0] r_skid_dir [3*AXES];
    logic [CW-1:0]        r_skid_ctr [AXES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (o_pose.ready) begin
                r_skid_vld <= 1'b0;
            end
        end else if (r_vld[LAT-1] && !o_pose.ready) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_vld) begin
            r_skid_dir <= w_dir;
            r_skid_ctr <= w_ctr;
        end
    end

    // Output selection: the skid register holds the older item.
    logic signed [OW-1:0] w_odir [3*AXES];
    logic [CW-1:0]        w_octr [AXES];
    always_comb begin
        if (r_skid_vld) begin
            w_odir = r_skid_dir;
            w_octr = r_skid_ctr;
        end else begin
            w_odir = w_dir;
            w_octr = w_ctr;
        end
    end

    assign o_pose.valid        = r_skid_vld || r_vld[LAT-1];
    assign o_pose.axis_x_dir_x = w_odir[0];
    assign o_pose.axis_x_dir_y = w_odir[1];
    assign o_pose.axis_x_dir_z = w_odir[2];
    assign o_pose.axis_y_dir_x = w_odir[3];
    assign o_pose.axis_y_dir_y = w_odir[4];
    assign o_pose.axis_y_dir_z = w_odir[5];
    assign o_pose.axis_z_dir_x = w_odir[6];
    assign o_pose.axis_z_dir_y = w_odir[7];
    assign o_pose.axis_z_dir_z = w_odir[8];
    assign o_pose.center_x     = $signed(w_octr[0]);
    assign o_pose.center_y     = $signed(w_octr[1]);
    assign o_pose.center_z     = $signed(w_octr[2]);

    localparam logic signed [OW-1:0] DIR_ONE = OW'(1) << FB;

    // While the skid register is full, no new item is taken in.
    a_skid_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> !i_corners.ready)
        else $error("input ready while the skid register is full");

    // A full skid register drains on the next edge once the sink takes it.
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld && o_pose.ready |=> !r_skid_vld)
        else $error("skid register did not drain");

    // While stalled, the stage valid bits do not move.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld && $past(r_skid_vld) |-> $stable(r_vld))
        else $error("pipeline moved during a stall");

    // The x components of the X and Z axis directions stay within plus and minus one.
    a_dir_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pose.valid |-> (o_pose.axis_z_dir_x <= DIR_ONE && o_pose.axis_z_dir_x >= -DIR_ONE
                          && o_pose.axis_x_dir_x <= DIR_ONE
                          && o_pose.axis_x_dir_x >= -DIR_ONE))
        else $error("direction component out of range");
endmodule
`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for the marker pose block with its own exact pose predictor.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = 32;
    localparam int FB = 16;
    localparam int LATENCY = FB + 9;
    localparam int RANDOM_ITEMS = 1100;
    localparam int CYCLE_LIMIT = 400000;
    localparam int STALL_AT = 200;
    localparam int STALL_LEN = 400;
    localparam int PAUSE_AT = 600;

    typedef logic [11:0][CW-1:0] corners_t;
    typedef struct packed {
        logic [8:0][FB+1:0] dir;
        logic [2:0][CW-1:0] ctr;
    } pose_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    mpc_corner_if #(.CW(CW)) corners_if ();
    mpc_pose_if #(.CW(CW), .FB(FB)) pose_if ();

    marker_pose_from_corners #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_corners (corners_if),
        .o_pose    (pose_if)
    );

    corners_t pending_corners[$];
    pose_t    expected_poses[$];
    int       sent_cnt = 0;
    int       recv_cnt = 0;
    int       errors = 0;
    int       cycles = 0;
    int       stall_left = 0;
    bit       stall_done = 1'b0;
    bit       pause_active = 1'b0;
    bit       pause_done = 1'b0;

    always #10 i_clk = ~i_clk;

    // Appends one marker to the stimulus queue.
    task automatic queue_corners(corners_t c);
        pending_corners = {pending_corners, c};
    endtask

    // Exact floor(v * 2^FB / sqrt(s)), found by bisection on the root.
    function automatic logic [FB+1:0] unit_component(logic signed [71:0] v, logic [255:0] s);
        logic [71:0]  vm;
        logic [255:0] vw, t, mw, p;
        int lo, hi, mid;
        if (s == '0) return '0;
        vm = v[71] ? -v : v;
        vw = {184'b0, vm};
        t = (vw * vw) << (2 * FB);
        lo = 0;
        hi = 1 << FB;
        while (lo < hi) begin
            mid = v[71] ? (lo + hi) / 2 : (lo + hi + 1) / 2;
            mw = mid;
            p = mw * mw * s;
            if (!v[71]) begin
                if (p <= t) lo = mid; else hi = mid - 1;
            end else begin
                if (p >= t) hi = mid; else lo = mid + 1;
            end
        end
        return v[71] ? FB'(0) - lo[FB+1:0] : lo[FB+1:0];
    endfunction

    // Normalizes one vector into three direction components.
    function automatic logic [2:0][FB+1:0] unit_vector(logic signed [71:0] v[3]);
        logic [255:0] s, m;
        logic [2:0][FB+1:0] dir;
        s = '0;
        for (int k = 0; k < 3; k++) begin
            m = {184'b0, (v[k][71] ? -v[k] : v[k])};
            s = s + m * m;
        end
        for (int k = 0; k < 3; k++) dir[k] = unit_component(v[k], s);
        return dir;
    endfunction

    // Full pose of one marker: axis columns and center.
    function automatic pose_t marker_pose(corners_t c);
        pose_t r;
        logic signed [71:0] xv[3], yv[3], zv[3];
        logic signed [CW+1:0] dx, dy;
        logic signed [CW+2:0] sz;
        int a, b;
        for (int k = 0; k < 3; k++) begin
            xv[k] = $signed(c[3 + k]) - $signed(c[k]);
            yv[k] = $signed(c[k]) - $signed(c[9 + k]);
        end
        for (int k = 0; k < 3; k++) begin
            a = (k + 1) % 3;
            b = (k + 2) % 3;
            zv[k] = xv[a] * yv[b] - xv[b] * yv[a];
        end
        r.dir[2:0] = unit_vector(xv);
        r.dir[5:3] = unit_vector(yv);
        r.dir[8:6] = unit_vector(zv);
        dx = $signed(c[3]) - $signed(c[0]);
        dy = $signed(c[10]) - $signed(c[1]);
        sz = $signed(c[2]) + $signed(c[5]) + $signed(c[8]) + $signed(c[11]);
        r.ctr[0] = CW'($signed(c[0]) + (dx >>> 1));
        r.ctr[1] = CW'($signed(c[1]) + (dy >>> 1));
        r.ctr[2] = CW'(sz >>> 2);
        return r;
    endfunction

    // Random marker: half clustered near a base per axis, some degenerate, some raw noise.
    function automatic corners_t random_marker();
        corners_t c;
        int kind;
        logic signed [CW-1:0] base, span;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 12; i++) c[i] = $urandom;
        if (kind < 5) begin
            for (int k = 0; k < 3; k++) begin
                base = $signed($urandom) >>> $urandom_range(0, 12);
                span = $urandom_range(0, 1) ? (1 << $urandom_range(0, 20)) : 0;
                for (int i = 0; i < 4; i++)
                    c[i * 3 + k] = base + ($signed($urandom_range(0, 2 * 65535)) - 65535)
                                   % (span + 1);
            end
        end else if (kind == 5) begin
            c[3 +: 3] = c[0 +: 3];
        end else if (kind == 6) begin
            c[9 +: 3] = c[0 +: 3];
        end else if (kind == 7) begin
            for (int k = 0; k < 3; k++) c[9 + k] = 2 * $signed(c[k]) - $signed(c[3 + k]);
        end
        return c;
    endfunction

    // Percent of cycles in which the sender or receiver idles, by stimulus phase.
    function automatic int send_idle_pct(int n);
        return n < 400 ? 10 : (n < 800 ? 61 : 0);
    endfunction
    function automatic int recv_idle_pct(int n);
        return n < 400 ? 61 : (n < 800 ? 10 : 0);
    endfunction

    // Driver: offers pending items and records the expected pose of each accepted one.
    always @(posedge i_clk) begin
        corners_t nxt;
        if (!i_rst_n) begin
            corners_if.valid <= 1'b0;
        end else begin
            if (corners_if.valid && corners_if.ready) begin
                expected_poses = {expected_poses, marker_pose({corners_if.corner3_z,
                    corners_if.corner3_y, corners_if.corner3_x, corners_if.corner2_z,
                    corners_if.corner2_y, corners_if.corner2_x, corners_if.corner1_z,
                    corners_if.corner1_y, corners_if.corner1_x, corners_if.corner0_z,
                    corners_if.corner0_y, corners_if.corner0_x})};
                sent_cnt <= sent_cnt + 1;
                if (sent_cnt + 1 == PAUSE_AT && !pause_done) begin
                    pause_active <= 1'b1;
                    pause_done <= 1'b1;
                end
            end
            if (pause_active && expected_poses.size() == 0) pause_active <= 1'b0;
            if (!corners_if.valid || corners_if.ready) begin
                if (pending_corners.size() != 0 && !pause_active
                        && !(corners_if.valid && corners_if.ready && sent_cnt + 1 == PAUSE_AT)
                        && $urandom_range(0, 99) >= send_idle_pct(sent_cnt)) begin
                    nxt = pending_corners.pop_front();
                    corners_if.corner0_x <= nxt[0];
                    corners_if.corner0_y <= nxt[1];
                    corners_if.corner0_z <= nxt[2];
                    corners_if.corner1_x <= nxt[3];
                    corners_if.corner1_y <= nxt[4];
                    corners_if.corner1_z <= nxt[5];
                    corners_if.corner2_x <= nxt[6];
                    corners_if.corner2_y <= nxt[7];
                    corners_if.corner2_z <= nxt[8];
                    corners_if.corner3_x <= nxt[9];
                    corners_if.corner3_y <= nxt[10];
                    corners_if.corner3_z <= nxt[11];
                    corners_if.valid <= 1'b1;
                end else begin
                    corners_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted pose against the oldest expectation and drives ready.
    always @(posedge i_clk) begin
        pose_t got, want;
        if (!i_rst_n) begin
            pose_if.ready <= 1'b0;
        end else begin
            if (pose_if.valid && pose_if.ready) begin
                got.dir = {pose_if.axis_z_dir_z, pose_if.axis_z_dir_y, pose_if.axis_z_dir_x,
                           pose_if.axis_y_dir_z, pose_if.axis_y_dir_y, pose_if.axis_y_dir_x,
                           pose_if.axis_x_dir_z, pose_if.axis_x_dir_y, pose_if.axis_x_dir_x};
                got.ctr = {pose_if.center_z, pose_if.center_y, pose_if.center_x};
                recv_cnt <= recv_cnt + 1;
                if (expected_poses.size() == 0) begin
                    $display("%0t: unexpected pose item, got %h", $time, got);
                    errors = errors + 1;
                end else begin
                    want = expected_poses.pop_front();
                    for (int i = 0; i < 9; i++)
                        if (got.dir[i] !== want.dir[i]) begin
                            $display("%0t: axis component %0d expected %0d got %0d", $time, i,
                                     $signed(want.dir[i]), $signed(got.dir[i]));
                            errors = errors + 1;
                        end
                    for (int i = 0; i < 3; i++)
                        if (got.ctr[i] !== want.ctr[i]) begin
                            $display("%0t: center %0d expected %0d got %0d", $time, i,
                                     $signed(want.ctr[i]), $signed(got.ctr[i]));
                            errors = errors + 1;
                        end
                end
            end
            // One long hold-off so the pipeline fills and stalls its input.
            if (!stall_done && recv_cnt >= STALL_AT) begin
                stall_left <= STALL_LEN;
                stall_done <= 1'b1;
                pose_if.ready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                pose_if.ready <= 1'b0;
            end else begin
                pose_if.ready <= $urandom_range(0, 99) >= recv_idle_pct(recv_cnt);
            end
        end
    end

    // Run-time limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Stimulus and end of run.
    initial begin
        corners_t c;
        corners_if.valid = 1'b0;
        corners_if.corner0_x = '0; corners_if.corner0_y = '0; corners_if.corner0_z = '0;
        corners_if.corner1_x = '0; corners_if.corner1_y = '0; corners_if.corner1_z = '0;
        corners_if.corner2_x = '0; corners_if.corner2_y = '0; corners_if.corner2_z = '0;
        corners_if.corner3_x = '0; corners_if.corner3_y = '0; corners_if.corner3_z = '0;
        pose_if.ready = 1'b0;

        // Directed markers: all zero, extremes, zero-length axes, unit square.
        queue_corners('0);
        queue_corners({12{32'h7fffffff}});
        queue_corners({12{32'h80000000}});
        for (int i = 0; i < 12; i++) c[i] = (i / 3) % 2 ? 32'h7fffffff : 32'h80000000;
        queue_corners(c);
        for (int i = 0; i < 12; i++) c[i] = (i / 3) % 2 ? 32'h80000000 : 32'h7fffffff;
        queue_corners(c);
        for (int i = 0; i < 12; i++) c[i] = (i % 3 == 2) ? 32'h7fffffff : 32'h80000000;
        queue_corners(c);
        for (int i = 0; i < 12; i++) c[i] = 32'hffffffff;
        c[3] = 32'h00000000;
        queue_corners(c);
        c = '0; c[3] = 32'h10000; c[10] = 32'h10000;
        queue_corners(c);
        c = '0; c[3] = 32'h10000; c[10] = -32'sh10000; c[2] = 1; c[5] = 2; c[8] = -3;
        queue_corners(c);
        c = '0; c[3] = -32'sh3; c[4] = 32'h4; c[9] = 32'h5; c[10] = 32'h5; c[11] = 32'h7;
        queue_corners(c);
        c = random_marker(); c[3 +: 3] = c[0 +: 3];
        queue_corners(c);
        c = random_marker(); c[9 +: 3] = c[0 +: 3];
        queue_corners(c);
        c = '0; c[3] = 32'h7fffffff; c[9] = 32'h80000000;
        queue_corners(c);
        c = '0; c[3] = 32'h7fffffff; c[4] = 32'h80000000; c[5] = 32'h7fffffff;
        c[9] = 32'h80000000; c[10] = 32'h7fffffff; c[11] = 32'h80000000;
        queue_corners(c);
        c = '0; c[1] = 32'h80000000; c[10] = 32'h7fffffff; c[0] = 32'h7fffffff;
        c[3] = 32'h80000000;
        queue_corners(c);
        c = '0; c[0] = -32'sh1; c[3] = 32'h0; c[1] = -32'sh1; c[10] = 32'h0;
        c[2] = -32'sh1; c[5] = 32'h0; c[8] = 32'h0; c[11] = 32'h0;
        queue_corners(c);
        for (int i = 0; i < RANDOM_ITEMS; i++) queue_corners(random_marker());

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_corners.size() != 0 || corners_if.valid || expected_poses.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (errors == 0 && expected_poses.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
